### rtl/krsq_pkg.sv
// Shared types and constants for the key repeat slot queue.
package krsq_pkg;

  localparam int unsigned RingDepth   = 64;
  localparam int unsigned RingAw      = $clog2(RingDepth);
  localparam int unsigned RepeatSlots = 6;
  localparam int unsigned SlotAw      = (RepeatSlots > 1) ? $clog2(RepeatSlots) : 1;
  localparam int unsigned CmdDepth    = 2;

  localparam logic [7:0] CtrlReleaseCode = 8'h9d;
  localparam logic [7:0] WinUsageLeft    = 8'he3;
  localparam logic [7:0] WinUsageRight   = 8'he7;
  localparam logic [7:0] ReprLimit       = 8'd127;

  typedef enum logic [1:0] {
    REQ_KEY  = 2'd0,
    REQ_PUSH = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_DELAY    = 3'd0,
    CFG_INTERVAL = 3'd1,
    CFG_SHIFT    = 3'd2,
    CFG_CTRL     = 3'd3,
    CFG_ALT      = 3'd4,
    CFG_CAPS     = 3'd5
  } cfg_e;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  usage;
    logic [7:0]  value;   // resolved event value or pushed value
    logic        pressed;
    logic [63:0] now;
    logic [4:0]  flags;   // modifier flags after the item
  } cmd_t;

  function automatic logic can_repeat(logic [7:0] v);
    return (v == 8'd8) || (v == 8'd10) || ((v >= 8'd32) && (v < ReprLimit));
  endfunction

endpackage

### rtl/key_repeat_slot_queue.sv
// Top level of the keyboard key repeat slot queue.
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   input   | in_valid_i / in_ready_o        | item in
//   result  | out_valid_o / out_ready_i      | item out
//   config  | cfg_valid_i / cfg_ready_o      | register write
//
// A key event or read passes the front look-up and hand-off, a serial scan of
// the six repeat slots, then a slot update or ring read; a push skips the scan,
// and an unused type goes straight to the result. The front takes no new item
// until it has handed off the last one; the back takes none until its result
// is taken. A stalled result holds the back, then the 2-entry
// queue fills and the input stalls. Reset clears flags, held-table valid bits,
// slots and ring pointers at once; there is no clearing pass.
module key_repeat_slot_queue import krsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  key_usage_i,
  input  logic [7:0]  key_value_i,
  input  logic        key_pressed_i,
  input  logic [63:0] now_ns_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_value_o,
  output logic [7:0]  resolved_value_o,
  output logic        shift_on_o,
  output logic        ctrl_on_o,
  output logic        alt_on_o,
  output logic        win_on_o,
  output logic        caps_on_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] delay_q, interval_q;
  logic [7:0]  shift_q, ctrl_q, alt_q, caps_q;
  logic        fc_valid, fc_ready, bc_valid, bc_ready;
  cmd_t        fc_cmd, bc_cmd;
  logic [4:0]  flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= 32'd500000000;
      interval_q <= 32'd25000000;
      shift_q    <= 8'd128;
      ctrl_q     <= 8'd129;
      alt_q      <= 8'd130;
      caps_q     <= 8'd131;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DELAY:    delay_q    <= cfg_data_i;
        CFG_INTERVAL: interval_q <= cfg_data_i;
        CFG_SHIFT:    shift_q    <= cfg_data_i[7:0];
        CFG_CTRL:     ctrl_q     <= cfg_data_i[7:0];
        CFG_ALT:      alt_q      <= cfg_data_i[7:0];
        CFG_CAPS:     caps_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  krsq_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .req_i(req_type_i), .usage_i(key_usage_i), .value_i(key_value_i),
    .pressed_i(key_pressed_i), .now_i(now_ns_i),
    .shift_code_i(shift_q), .ctrl_code_i(ctrl_q), .alt_code_i(alt_q),
    .caps_code_i(caps_q),
    .cmd_valid_o(fc_valid), .cmd_ready_i(fc_ready), .cmd_o(fc_cmd)
  );

  krsq_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fc_valid), .wr_ready_o(fc_ready), .wr_data_i(fc_cmd),
    .rd_valid_o(bc_valid), .rd_ready_i(bc_ready), .rd_data_o(bc_cmd)
  );

  krsq_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(bc_valid), .cmd_ready_o(bc_ready), .cmd_i(bc_cmd),
    .delay_i(delay_q), .interval_i(interval_q), .ctrl_code_i(ctrl_q),
    .out_valid_o, .out_ready_i,
    .read_value_o, .resolved_value_o, .flags_o(flags)
  );

  assign shift_on_o = flags[0];
  assign ctrl_on_o  = flags[1];
  assign alt_on_o   = flags[2];
  assign win_on_o   = flags[3];
  assign caps_on_o  = flags[4];

endmodule

### rtl/krsq_front.sv
// Front end: modifier flags, held value table, classification of items.
module krsq_front import krsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_i,
  input  logic [7:0]  usage_i,
  input  logic [7:0]  value_i,
  input  logic        pressed_i,
  input  logic [63:0] now_i,
  input  logic [7:0]  shift_code_i,
  input  logic [7:0]  ctrl_code_i,
  input  logic [7:0]  alt_code_i,
  input  logic [7:0]  caps_code_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LOOK = 3'b010,
    F_SEND = 3'b100
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [4:0]  flags_q, flags_d;
  logic [255:0] hvalid_q;
  logic [7:0]  held_mem [256];
  logic [7:0]  held_rd_q;
  logic [1:0]  req_q;
  logic [7:0]  usage_q, value_q;
  logic        pressed_q;
  logic [63:0] now_q;
  cmd_t        cmd_q;
  logic [7:0]  ev;
  logic [7:0]  held_val;

  assign in_ready_o  = (state_q == F_IDLE);
  assign cmd_valid_o = (state_q == F_SEND);
  assign cmd_o       = cmd_q;
  assign held_val    = hvalid_q[usage_q] ? held_rd_q : 8'd0;
  assign ev          = (!pressed_q && value_q == 8'd0) ? held_val : value_q;

  always_comb begin
    flags_d = flags_q;
    if (value_q == shift_code_i) flags_d[0] = pressed_q;
    else if (value_q == ctrl_code_i) flags_d[1] = pressed_q;
    else if (value_q == alt_code_i) flags_d[2] = pressed_q;
    else if (usage_q == WinUsageLeft || usage_q == WinUsageRight) flags_d[3] = pressed_q;
    else if (value_q == caps_code_i && pressed_q) flags_d[4] = ~flags_q[4];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_LOOK;
      F_LOOK: state_d = F_SEND;
      F_SEND: if (cmd_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      flags_q  <= '0;
      hvalid_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_LOOK && req_q == REQ_KEY) begin
        flags_q <= flags_d;
        hvalid_q[usage_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_rd_q <= held_mem[usage_i];
    if (state_q == F_LOOK && req_q == REQ_KEY) begin
      held_mem[usage_q] <= pressed_q ? ev : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q     <= req_i;
      usage_q   <= usage_i;
      value_q   <= value_i;
      pressed_q <= pressed_i;
      now_q     <= now_i;
    end
    if (state_q == F_LOOK) begin
      cmd_q.req     <= req_q;
      cmd_q.usage   <= usage_q;
      cmd_q.value   <= (req_q == REQ_KEY) ? ev : value_q;
      cmd_q.pressed <= pressed_q;
      cmd_q.now     <= now_q;
      cmd_q.flags   <= (req_q == REQ_KEY) ? flags_d : flags_q;
    end
  end

endmodule

### rtl/krsq_cmd_fifo.sv
// Short command queue between front and back.
module krsq_cmd_fifo import krsq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  localparam int unsigned Aw = $clog2(CmdDepth);

  cmd_t            mem_q [CmdDepth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;
  logic            wr, rd;

  assign wr_ready_o = (cnt_q != Aw'(0) + (Aw+1)'(CmdDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(CmdDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == Aw'(CmdDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

### rtl/krsq_back.sv
// Back end: repeat slots, byte ring and result register.
module krsq_back import krsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic [31:0] delay_i,
  input  logic [31:0] interval_i,
  input  logic [7:0]  ctrl_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_value_o,
  output logic [7:0]  resolved_value_o,
  output logic [4:0]  flags_o
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SCAN = 5'b00010,   // slot match/free search or due scan
    B_ACT  = 5'b00100,   // slot update and enqueue
    B_GET  = 5'b01000,   // ring read
    B_OUT  = 5'b10000
  } bstate_e;

  bstate_e      state_q;
  cmd_t         c_q;
  logic [SlotAw-1:0] idx_q;
  logic         match_f_q, free_f_q;
  logic [SlotAw-1:0] match_q, free_q;
  logic [RepeatSlots-1:0] act_q;
  logic [7:0]   susage_q [RepeatSlots];
  logic [7:0]   svalue_q [RepeatSlots];
  logic [63:0]  sdue_q   [RepeatSlots];
  logic [7:0]   ring_mem [RingDepth];
  logic [RingAw-1:0] head_q, tail_q;
  logic [7:0]   rdv_q, evv_q;
  logic [RingAw-1:0] head_nx;
  logic         put_en;
  logic [7:0]   put_val;
  logic         last_slot;
  logic [SlotAw-1:0] tgt;

  assign cmd_ready_o      = (state_q == B_IDLE);
  assign out_valid_o      = (state_q == B_OUT);
  assign read_value_o     = rdv_q;
  assign resolved_value_o = evv_q;
  assign flags_o          = c_q.flags;
  assign last_slot        = (idx_q == SlotAw'(RepeatSlots - 1));
  assign head_nx          = (head_q == RingAw'(RingDepth - 1)) ? '0 : head_q + 1'b1;
  assign tgt              = match_f_q ? match_q : free_q;

  // One ring write per cycle at most.
  always_comb begin
    put_en  = 1'b0;
    put_val = 8'd0;
    case (state_q)
      B_SCAN: if (c_q.req == REQ_READ && c_q.now != 64'd0 && act_q[idx_q]
                  && c_q.now >= sdue_q[idx_q]) begin
        put_en  = 1'b1;
        put_val = svalue_q[idx_q];
      end
      B_ACT: begin
        put_en = (c_q.req == REQ_PUSH) || (c_q.req == REQ_KEY &&
                 (c_q.pressed || c_q.value == ctrl_code_i));
        put_val = (c_q.req == REQ_KEY && !c_q.pressed) ? CtrlReleaseCode : c_q.value;
      end
      default: ;
    endcase
  end

  // Ring write, and the registered ring read in B_GET after the last scan write
  always_ff @(posedge clk_i) begin
    if (put_en && put_val != 8'd0 && head_nx != tail_q) ring_mem[head_q] <= put_val;
    if (state_q == B_IDLE && cmd_valid_i) begin
      rdv_q <= 8'd0;
    end else if (state_q == B_GET && tail_q != head_q) begin
      rdv_q <= ring_mem[tail_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      act_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      idx_q   <= '0;
      match_f_q <= 1'b0;
      free_f_q  <= 1'b0;
    end else begin
      if (put_en && put_val != 8'd0 && head_nx != tail_q) head_q <= head_nx;
      case (state_q)
        B_IDLE: if (cmd_valid_i) begin
          idx_q     <= '0;
          match_f_q <= 1'b0;
          free_f_q  <= 1'b0;
          if (cmd_i.req == REQ_NONE) state_q <= B_OUT;
          else if (cmd_i.req == REQ_PUSH) state_q <= B_ACT;
          else state_q <= B_SCAN;
        end
        B_SCAN: begin
          if (c_q.req == REQ_KEY) begin
            if (act_q[idx_q] && susage_q[idx_q] == c_q.usage) begin
              match_f_q <= 1'b1;
              match_q   <= idx_q;
            end else if (!act_q[idx_q] && !free_f_q) begin
              free_f_q <= 1'b1;
              free_q   <= idx_q;
            end
          end else if (put_en) begin
            sdue_q[idx_q] <= c_q.now + 64'(interval_i);
          end
          idx_q <= idx_q + 1'b1;
          if (last_slot) state_q <= (c_q.req == REQ_KEY) ? B_ACT : B_GET;
        end
        B_ACT: begin
          if (c_q.req == REQ_KEY) begin
            if (c_q.pressed) begin
              if (can_repeat(c_q.value) && (match_f_q || free_f_q)) begin
                act_q[tgt]    <= 1'b1;
                susage_q[tgt] <= c_q.usage;
                svalue_q[tgt] <= c_q.value;
                sdue_q[tgt]   <= (c_q.now != 64'd0) ? c_q.now + 64'(delay_i) : 64'd0;
              end
            end else if (match_f_q) begin
              act_q[match_q] <= 1'b0;
            end
          end
          state_q <= B_OUT;
        end
        B_GET: state_q <= B_OUT;
        B_OUT: if (out_ready_i) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
      if (state_q == B_GET && tail_q != head_q) begin
        tail_q <= (tail_q == RingAw'(RingDepth - 1)) ? '0 : tail_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && cmd_valid_i) begin
      c_q   <= cmd_i;
      evv_q <= (cmd_i.req == REQ_KEY) ? cmd_i.value : 8'd0;
    end
  end

endmodule

### rtl/krsq_checker.sv
// Port-level checker for the key repeat slot queue, bound to the top level.
module krsq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_value_o,
  input logic [7:0] resolved_value_o,
  input logic       cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o))
    else $error("result changed while stalled");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_value_o == 8'd0 || resolved_value_o == 8'd0))
    else $error("read and event values both set");

  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

  a_out_hold_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(resolved_value_o))
    else $error("event value changed while stalled");

endmodule

bind key_repeat_slot_queue krsq_checker u_krsq_checker (.*);

### verif/key_repeat_slot_queue_tb.sv
// Testbench for the key repeat slot queue: predicted results checked per item.
`timescale 1ns / 1ps

module key_repeat_slot_queue_tb;
  import krsq_pkg::*;

  // Expected result of one item
  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] ev;
    logic [4:0] flags;
  } key_result_t;

  // Keeps its own copy of the engine state and predicts one result per item.
  class typematic_scoreboard;
    logic [31:0] delay_ns, interval_ns;
    logic [7:0]  shift_c, ctrl_c, alt_c, caps_c;
    logic [7:0]  ring [RingDepth];
    int unsigned head, tail;
    bit          act [RepeatSlots];
    logic [7:0]  s_usage [RepeatSlots];
    logic [7:0]  s_value [RepeatSlots];
    logic [63:0] s_due [RepeatSlots];
    logic [7:0]  held [256];
    logic [4:0]  flags;
    key_result_t pending[$];
    int          errors;

    function new();
      delay_ns = 500000000; interval_ns = 25000000;
      shift_c = 128; ctrl_c = 129; alt_c = 130; caps_c = 131;
      head = 0; tail = 0; flags = '0; errors = 0;
      foreach (act[i]) act[i] = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function void write_reg(cfg_e idx, logic [31:0] d);
      case (idx)
        CFG_DELAY:    delay_ns = d;
        CFG_INTERVAL: interval_ns = d;
        CFG_SHIFT:    shift_c = d[7:0];
        CFG_CTRL:     ctrl_c = d[7:0];
        CFG_ALT:      alt_c = d[7:0];
        CFG_CAPS:     caps_c = d[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned fill();
      return (head + RingDepth - tail) % RingDepth;
    endfunction

    function void enqueue(logic [7:0] v);
      int unsigned nxt;
      nxt = (head + 1) % RingDepth;
      if (v == 0 || nxt == tail) return;
      ring[head] = v;
      head = nxt;
    endfunction

    function bit repeatable(logic [7:0] v);
      return v == 8 || v == 10 || (v >= 32 && v < 127);
    endfunction

    function void note_item(req_e req, logic [7:0] usage, logic [7:0] value,
                            bit pressed, logic [63:0] now);
      key_result_t r;
      int          match, free_idx, s;
      logic [7:0]  ev;
      match = -1; free_idx = -1;
      r = '0;
      if (req == REQ_KEY) begin
        ev = value;
        // first matching modifier wins
        if (value == shift_c) flags[0] = pressed;
        else if (value == ctrl_c) flags[1] = pressed;
        else if (value == alt_c) flags[2] = pressed;
        else if (usage == WinUsageLeft || usage == WinUsageRight) flags[3] = pressed;
        else if (value == caps_c && pressed) flags[4] = ~flags[4];
        if (!pressed && ev == 0) ev = held[usage];
        held[usage] = pressed ? ev : 8'd0;
        for (int i = 0; i < RepeatSlots; i++) begin
          if (act[i] && s_usage[i] == usage) match = i;
          else if (!act[i] && free_idx < 0) free_idx = i;
        end
        if (pressed) begin
          enqueue(ev);
          if (repeatable(ev)) begin
            s = (match >= 0) ? match : free_idx;
            if (s >= 0) begin
              act[s] = 1; s_usage[s] = usage; s_value[s] = ev;
              s_due[s] = (now != 0) ? now + 64'(delay_ns) : 64'd0;
            end
          end
        end else begin
          if (match >= 0) act[match] = 0;
          if (ev == ctrl_c) enqueue(CtrlReleaseCode);
        end
        r.ev = ev;
      end else if (req == REQ_PUSH) begin
        enqueue(value);
      end else if (req == REQ_READ) begin
        if (now != 0) begin
          for (int i = 0; i < RepeatSlots; i++) begin
            if (act[i] && now >= s_due[i]) begin
              enqueue(s_value[i]);
              s_due[i] = now + 64'(interval_ns);
            end
          end
        end
        if (tail != head) begin
          r.rd = ring[tail];
          tail = (tail + 1) % RingDepth;
        end
      end
      r.flags = flags;
      pending.push_back(r);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task check_result(key_result_t got);
      key_result_t want;
      if (pending.size() == 0) begin
        report("unexpected item", got.rd, 8'd0);
        return;
      end
      want = pending.pop_front();
      if (got.rd !== want.rd) report("read_value", got.rd, want.rd);
      if (got.ev !== want.ev) report("resolved_value", got.ev, want.ev);
      if (got.flags !== want.flags) report("flags", 8'(got.flags), 8'(want.flags));
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0]  req_type_i;
  logic [7:0]  key_usage_i, key_value_i, read_value_o, resolved_value_o;
  logic        key_pressed_i;
  logic [63:0] now_ns_i;
  logic        shift_on_o, ctrl_on_o, alt_on_o, win_on_o, caps_on_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  key_repeat_slot_queue u_top (.*);

  typematic_scoreboard sb;
  logic [63:0] clock_ns;   // simulated keyboard time, kept increasing mostly
  int          idle_cycles;
  bit          hold_sink;  // long receiver stall requested
  bit          sink_held;  // receiver stall has finished
  bit          done;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: cycles without any handshake on the input, result or config port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, one long stall on request
  initial begin
    int gap;
    out_ready_i = 0;
    sink_held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink && !sink_held) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        sink_held = 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (idle_cycles > 50 || $urandom_range(0, 7) == 0) gap = 0;
      if (gap > 0) begin
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      #0;
    end
  end

  // Sample results on the clock edge via the handshake values before the NBA update
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({read_value_o, resolved_value_o,
                       caps_on_o, win_on_o, alt_on_o, ctrl_on_o, shift_on_o});
  end

  task send_item(req_e req, logic [7:0] usage, logic [7:0] value, bit pressed,
                 logic [63:0] now);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1;
    req_type_i    <= req;
    key_usage_i   <= usage;
    key_value_i   <= value;
    key_pressed_i <= pressed;
    now_ns_i      <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(req, usage, value, pressed, now);
  endtask

  task drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task write_reg(cfg_e idx, logic [31:0] d);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // Time step for the next item: mostly forward, sometimes zero or a random value
  function logic [63:0] next_now();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 64'd0;
    if (sel == 1) return {$urandom, $urandom};
    clock_ns = clock_ns + $urandom_range(0, 40000);
    return clock_ns;
  endfunction

  function logic [7:0] rand_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 8'($urandom_range(128, 131));
      1: return 8'd0;
      2: return ($urandom_range(0, 1) != 0) ? 8'd8 : 8'd10;
      3, 4: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // Random phase: press/hold/read sequences plus noise
  task random_phase(int n, int usage_span);
    logic [7:0] u, v;
    int         sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 19);
      u = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(224, 224 + usage_span));
      if (sel < 6) begin
        v = rand_value();
        send_item(REQ_KEY, u, v, 1'b1, next_now());
      end else if (sel < 10) begin
        v = ($urandom_range(0, 1) != 0) ? 8'd0 : rand_value();
        send_item(REQ_KEY, u, v, 1'b0, next_now());
      end else if (sel < 12) begin
        send_item(REQ_PUSH, 8'd0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  next_now());
      end else if (sel < 19) begin
        send_item(REQ_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), next_now());
      end else begin
        send_item(REQ_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    sb = new();
    clock_ns = 64'd1000;
    hold_sink = 0;
    done = 0;
    idle_cycles = 0;
    rst_ni = 0;
    in_valid_i = 0; req_type_i = REQ_NONE; key_usage_i = 0; key_value_i = 0;
    key_pressed_i = 0; now_ns_i = 0;
    cfg_valid_i = 0; cfg_index_i = CFG_DELAY; cfg_data_i = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, modifiers, recall, ctrl release, wrap, unknown time
    send_item(REQ_KEY, 8'h04, 8'd97, 1'b1, 64'd100);
    send_item(REQ_KEY, 8'h04, 8'd0, 1'b0, 64'd200);
    send_item(REQ_KEY, 8'he1, 8'd128, 1'b1, 64'd300);
    send_item(REQ_KEY, 8'he0, 8'd129, 1'b1, 64'd300);
    send_item(REQ_KEY, 8'he2, 8'd130, 1'b1, 64'd300);
    send_item(REQ_KEY, WinUsageLeft, 8'd5, 1'b1, 64'd300);
    send_item(REQ_KEY, 8'h39, 8'd131, 1'b1, 64'd300);
    send_item(REQ_KEY, 8'h39, 8'd131, 1'b0, 64'd300);
    send_item(REQ_KEY, WinUsageRight, 8'd129, 1'b0, 64'd400);
    send_item(REQ_KEY, 8'he1, 8'd0, 1'b0, 64'd400);
    send_item(REQ_KEY, WinUsageLeft, 8'd0, 1'b0, 64'd400);
    send_item(REQ_KEY, 8'hff, 8'hff, 1'b1, 64'hffff_ffff_ffff_fff0);
    send_item(REQ_KEY, 8'h00, 8'd32, 1'b1, 64'd0);
    send_item(REQ_READ, 8'hff, 8'hff, 1'b1, 64'd0);
    send_item(REQ_READ, 8'd0, 8'd0, 1'b0, 64'hffff_ffff_ffff_ffff);
    send_item(REQ_PUSH, 8'hff, 8'hff, 1'b1, 64'hffff_ffff_ffff_ffff);
    send_item(REQ_PUSH, 8'd0, 8'd0, 1'b0, 64'd1);
    send_item(REQ_NONE, 8'hff, 8'hff, 1'b1, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 8; i++) send_item(REQ_READ, 8'd0, 8'd0, 1'b0, 64'd600000000);
    drain();

    // Short times so repeats fire often
    write_reg(CFG_DELAY, 32'd20000);
    write_reg(CFG_INTERVAL, 32'd5000);
    write_reg(CFG_SHIFT, 32'hffff_ff00);
    write_reg(CFG_CTRL, 32'd255);
    write_reg(CFG_ALT, 32'd97);
    write_reg(CFG_CAPS, 32'd8);
    random_phase(450, 9);
    drain();

    // Fill the ring beyond capacity while the receiver is held off
    hold_sink = 1;
    for (int i = 0; i < 70; i++) send_item(REQ_PUSH, 8'd0, 8'(i + 1), 1'b0, 64'd0);
    while (!sink_held) @(posedge clk_i);
    for (int i = 0; i < 70; i++) send_item(REQ_READ, 8'd0, 8'd0, 1'b0, 64'd0);
    drain();

    write_reg(CFG_DELAY, 32'd0);
    write_reg(CFG_INTERVAL, 32'd0);
    write_reg(CFG_SHIFT, 32'd128);
    write_reg(CFG_CTRL, 32'd129);
    write_reg(CFG_ALT, 32'd130);
    write_reg(CFG_CAPS, 32'd131);
    random_phase(400, 15);
    drain();

    write_reg(CFG_DELAY, 32'hffff_ffff);
    write_reg(CFG_INTERVAL, 32'hffff_ffff);
    write_reg(CFG_CTRL, 32'd0);
    write_reg(CFG_CAPS, 32'd0);
    random_phase(200, 7);
    drain();

    write_reg(CFG_DELAY, 32'd30000);
    write_reg(CFG_INTERVAL, 32'd10000);
    write_reg(CFG_CTRL, 32'd129);
    write_reg(CFG_CAPS, 32'd131);
    random_phase(450, 5);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
